// ===== design/tlx_pkg.sv =====
// ----------------------------------------------------------------------------
// tlx_pkg
// Shared types, constants and character-class functions of the token lexer.
// ----------------------------------------------------------------------------
package tlx_pkg;

    localparam int MaxLineBytesDef = 4096;
    localparam int ColW   = 13;
    localparam int QDepth = 4;
    localparam int QPtrW  = 2;
    localparam int ResMax = 3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNK   = 2'd1;
    localparam logic [1:0] ST_UNTRM = 2'd2;
    localparam logic [1:0] ST_LONG  = 2'd3;

    localparam logic [5:0] K_FIXNUM = 6'd48;
    localparam logic [5:0] K_NUMBER = 6'd49;
    localparam logic [5:0] K_IDENT  = 6'd50;
    localparam logic [5:0] K_STRING = 6'd51;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_ZERO, M_DEC, M_FIX, M_HEX0, M_HEX, M_BIN0, M_BIN,
        M_OP, M_STR, M_ESC, M_COMMENT
    } t_mode;

    typedef struct packed {
        logic [5:0]  kind;
        logic [1:0]  status;
        logic [11:0] col;
        logic [12:0] len;
    } t_res;

    typedef struct packed {
        t_res [ResMax-1:0] r;
        logic [1:0]        cnt;
        logic [15:0]       line;
    } t_bundle;

    localparam logic [63:0] KW_TEXT [13] = '{
        64'h0000_0000_0069_6e74,   // int
        64'h0000_0066_6978_6564,   // fixed
        64'h0000_0000_0070_7472,   // ptr
        64'h0000_0000_766f_6964,   // void
        64'h6675_6e63_7469_6f6e,   // function
        64'h0000_696e_6c69_6e65,   // inline
        64'h0000_0000_0000_6966,   // if
        64'h0000_0000_656c_7365,   // else
        64'h0000_7265_7475_726e,   // return
        64'h0000_0077_6869_6c65,   // while
        64'h0000_0000_0066_6f72,   // for
        64'h636f_6e74_696e_7565,   // continue
        64'h0000_0062_7265_616b    // break
    };
    localparam logic [3:0] KW_LEN [13] = '{
        4'd3, 4'd5, 4'd3, 4'd4, 4'd8, 4'd6, 4'd2, 4'd4, 4'd6, 4'd5, 4'd3, 4'd8, 4'd5
    };

    function automatic logic is_digit(logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_alpha(logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
    endfunction

    function automatic logic is_hex(logic [7:0] b);
        return is_digit(b) || (b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46);
    endfunction

    function automatic logic is_word(logic [7:0] b);
        return is_alpha(b) || is_digit(b) || b == 8'h5f;
    endfunction

    function automatic logic is_space(logic [7:0] b);
        return b == 8'h09 || b == 8'h0a || b == 8'h0c || b == 8'h0d || b == 8'h20;
    endfunction

    // {valid, kind}
    function automatic logic [6:0] single_kind(logic [7:0] b);
        logic [6:0] k;
        unique case (b)
            8'h3c:   k = {1'b1, 6'd37};
            8'h3e:   k = {1'b1, 6'd36};
            8'h26:   k = {1'b1, 6'd29};
            8'h7c:   k = {1'b1, 6'd30};
            8'h2b:   k = {1'b1, 6'd23};
            8'h2d:   k = {1'b1, 6'd24};
            8'h2a:   k = {1'b1, 6'd25};
            8'h2f:   k = {1'b1, 6'd26};
            8'h25:   k = {1'b1, 6'd27};
            8'h3d:   k = {1'b1, 6'd39};
            8'h21:   k = {1'b1, 6'd38};
            default: k = 7'd0;
        endcase
        return k;
    endfunction

    function automatic logic [6:0] pair_kind(logic [7:0] a, logic [7:0] b);
        logic [6:0] k;
        k = 7'd0;
        if (a == 8'h3c && b == 8'h3c) k = {1'b1, 6'd13};
        else if (a == 8'h3e && b == 8'h3e) k = {1'b1, 6'd14};
        else if (a == 8'h3c && b == 8'h2d) k = {1'b1, 6'd15};
        else if (a == 8'h26 && b == 8'h26) k = {1'b1, 6'd16};
        else if (a == 8'h7c && b == 8'h7c) k = {1'b1, 6'd17};
        else if (b == 8'h3d) begin
            unique case (a)
                8'h2b:   k = {1'b1, 6'd18};
                8'h2d:   k = {1'b1, 6'd19};
                8'h2a:   k = {1'b1, 6'd20};
                8'h2f:   k = {1'b1, 6'd21};
                8'h25:   k = {1'b1, 6'd22};
                8'h3e:   k = {1'b1, 6'd32};
                8'h3c:   k = {1'b1, 6'd33};
                8'h3d:   k = {1'b1, 6'd34};
                8'h21:   k = {1'b1, 6'd35};
                default: k = 7'd0;
            endcase
        end
        return k;
    endfunction

    function automatic logic [6:0] imm_kind(logic [7:0] b);
        logic [6:0] k;
        unique case (b)
            8'h7e:   k = {1'b1, 6'd28};
            8'h5e:   k = {1'b1, 6'd31};
            8'h7b:   k = {1'b1, 6'd40};
            8'h7d:   k = {1'b1, 6'd41};
            8'h28:   k = {1'b1, 6'd42};
            8'h29:   k = {1'b1, 6'd43};
            8'h5b:   k = {1'b1, 6'd44};
            8'h5d:   k = {1'b1, 6'd45};
            8'h2c:   k = {1'b1, 6'd46};
            8'h3b:   k = {1'b1, 6'd47};
            default: k = 7'd0;
        endcase
        return k;
    endfunction

    // Keyword kind for a whole word, else identifier with its length.
    function automatic t_res word_res(logic [63:0] pf, logic [11:0] ts, logic [12:0] len);
        t_res r;
        r = '{kind: K_IDENT, status: ST_OK, col: ts, len: len};
        for (int i = 0; i < 13; i++) begin
            if (len == {9'd0, KW_LEN[i]} && pf == KW_TEXT[i]) begin
                r.kind = 6'(i);
                r.len  = 13'd0;
            end
        end
        return r;
    endfunction

    function automatic t_bundle add_res(t_bundle bd, t_res r);
        t_bundle o;
        o = bd;
        unique case (bd.cnt)
            2'd0:    begin o.r[0] = r; o.cnt = 2'd1; end
            2'd1:    begin o.r[1] = r; o.cnt = 2'd2; end
            2'd2:    begin o.r[2] = r; o.cnt = 2'd3; end
            default: o = bd;
        endcase
        return o;
    endfunction

endpackage

// ===== design/tlx_if.sv =====
// ----------------------------------------------------------------------------
// tlx_in_if / tlx_out_if
// Valid/ready channels carrying source bytes in and tokens out.
// ----------------------------------------------------------------------------
interface tlx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_line;
    modport source (output valid, char_byte, end_of_line, input ready);
    modport sink (input valid, char_byte, end_of_line, output ready);
endinterface

interface tlx_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [1:0]  status;
    logic [15:0] line_number;
    logic [11:0] start_column;
    logic [12:0] value_length;
    logic        last_result;
    modport source (output valid, token_kind, status, line_number, start_column,
                    value_length, last_result, input ready);
    modport sink (input valid, token_kind, status, line_number, start_column,
                  value_length, last_result, output ready);
endinterface

// ===== design/tlx_front.sv =====
// ----------------------------------------------------------------------------
// tlx_front
// Scanner state and byte classification; builds one result bundle per input item.
// ----------------------------------------------------------------------------
module tlx_front #(
    parameter int MAX_LINE_BYTES = tlx_pkg::MaxLineBytesDef
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_char_byte,
    input  logic             i_end_of_line,
    input  logic             i_q_full,
    output logic             o_ready,
    output logic             o_push,
    output tlx_pkg::t_bundle o_bundle
);
    localparam logic [tlx_pkg::ColW-1:0] MaxCol = tlx_pkg::ColW'(MAX_LINE_BYTES);

    tlx_pkg::t_mode r_mode, n_mode;
    logic [11:0] r_ts, n_ts;
    logic [tlx_pkg::ColW-1:0] r_col, n_col;
    logic [7:0]  r_h0, n_h0, r_h1, n_h1;
    logic [63:0] r_pf, n_pf;
    logic [15:0] r_line, n_line;
    logic        r_err, n_err;
    tlx_pkg::t_bundle bd;

    always_comb begin
        logic        done;
        logic [7:0]  b;
        logic [6:0]  k;
        logic [12:0] c;
        n_mode = r_mode;
        n_ts   = r_ts;
        n_col  = r_col;
        n_h0   = r_h0;
        n_h1   = r_h1;
        n_pf   = r_pf;
        n_line = r_line;
        n_err  = r_err;
        bd     = '0;
        bd.line = r_line;
        b    = i_char_byte;
        c    = r_col;
        done = 1'b0;
        k    = '0;
        if (i_end_of_line) begin
            unique case (r_mode)
                tlx_pkg::M_IDENT:
                    bd = tlx_pkg::add_res(bd, tlx_pkg::word_res(r_pf, r_ts, c - 13'(r_ts)));
                tlx_pkg::M_ZERO, tlx_pkg::M_DEC, tlx_pkg::M_HEX, tlx_pkg::M_BIN:
                    bd = tlx_pkg::add_res(bd, '{tlx_pkg::K_NUMBER, tlx_pkg::ST_OK, r_ts,
                                                c - 13'(r_ts)});
                tlx_pkg::M_FIX:
                    bd = tlx_pkg::add_res(bd, '{tlx_pkg::K_FIXNUM, tlx_pkg::ST_OK, r_ts,
                                                c - 13'(r_ts)});
                tlx_pkg::M_HEX0, tlx_pkg::M_BIN0: begin
                    bd = tlx_pkg::add_res(bd, '{tlx_pkg::K_NUMBER, tlx_pkg::ST_OK, r_ts,
                                                13'd1});
                    n_ts = r_ts + 12'd1;
                    n_pf = {56'd0, r_h1};
                    bd = tlx_pkg::add_res(bd, tlx_pkg::word_res(n_pf, n_ts, c - 13'(n_ts)));
                end
                tlx_pkg::M_OP: begin
                    k = tlx_pkg::single_kind(r_h0);
                    bd = tlx_pkg::add_res(bd, '{k[5:0], tlx_pkg::ST_OK, r_ts, 13'd0});
                end
                tlx_pkg::M_STR, tlx_pkg::M_ESC: begin
                    bd = tlx_pkg::add_res(bd, '{6'd0, tlx_pkg::ST_UNTRM, r_ts, 13'd0});
                    n_err = 1'b1;
                end
                default: ;
            endcase
            n_mode = tlx_pkg::M_IDLE;
            n_col  = '0;
            if (r_line != 16'hFFFF) n_line = r_line + 16'd1;
        end else if (r_col >= MaxCol) begin
            bd = tlx_pkg::add_res(bd, '{6'd0, tlx_pkg::ST_LONG, 12'd0, 13'd0});
            n_err  = 1'b1;
            n_mode = tlx_pkg::M_IDLE;
        end else begin
            n_col = r_col + 1'b1;
            // At most three passes: finish a token, fall back from a prefix, start anew.
            for (int p = 0; p < 3; p++) begin
                if (!done) begin
                    unique case (n_mode)
                        tlx_pkg::M_IDENT: begin
                            if (tlx_pkg::is_word(b)) begin
                                if (c - 13'(n_ts) < 13'd8) n_pf = {n_pf[55:0], b};
                                done = 1'b1;
                            end else begin
                                bd = tlx_pkg::add_res(bd,
                                         tlx_pkg::word_res(n_pf, n_ts, c - 13'(n_ts)));
                                n_mode = tlx_pkg::M_IDLE;
                            end
                        end
                        tlx_pkg::M_ZERO, tlx_pkg::M_DEC: begin
                            done = 1'b1;
                            if (n_mode == tlx_pkg::M_ZERO && (b == 8'h78 || b == 8'h62)) begin
                                n_h1   = b;
                                n_mode = (b == 8'h78) ? tlx_pkg::M_HEX0 : tlx_pkg::M_BIN0;
                            end else if (tlx_pkg::is_digit(b)) begin
                                n_mode = tlx_pkg::M_DEC;
                            end else if (b == 8'h2e) begin
                                n_mode = tlx_pkg::M_FIX;
                            end else begin
                                bd = tlx_pkg::add_res(bd, '{tlx_pkg::K_NUMBER, tlx_pkg::ST_OK,
                                                            n_ts, c - 13'(n_ts)});
                                n_mode = tlx_pkg::M_IDLE;
                                done   = 1'b0;
                            end
                        end
                        tlx_pkg::M_FIX: begin
                            if (tlx_pkg::is_digit(b)) done = 1'b1;
                            else begin
                                bd = tlx_pkg::add_res(bd, '{tlx_pkg::K_FIXNUM, tlx_pkg::ST_OK,
                                                            n_ts, c - 13'(n_ts)});
                                n_mode = tlx_pkg::M_IDLE;
                            end
                        end
                        tlx_pkg::M_HEX0, tlx_pkg::M_BIN0: begin
                            if (n_mode == tlx_pkg::M_HEX0 ? tlx_pkg::is_hex(b)
                                                          : (b == 8'h30 || b == 8'h31)) begin
                                n_mode = (n_mode == tlx_pkg::M_HEX0) ? tlx_pkg::M_HEX
                                                                      : tlx_pkg::M_BIN;
                                done = 1'b1;
                            end else begin
                                bd = tlx_pkg::add_res(bd, '{tlx_pkg::K_NUMBER, tlx_pkg::ST_OK,
                                                            n_ts, 13'd1});
                                n_ts   = n_ts + 12'd1;
                                n_pf   = {56'd0, n_h1};
                                n_mode = tlx_pkg::M_IDENT;
                            end
                        end
                        tlx_pkg::M_HEX, tlx_pkg::M_BIN: begin
                            if (n_mode == tlx_pkg::M_HEX ? tlx_pkg::is_hex(b)
                                                         : (b == 8'h30 || b == 8'h31)) begin
                                done = 1'b1;
                            end else begin
                                bd = tlx_pkg::add_res(bd, '{tlx_pkg::K_NUMBER, tlx_pkg::ST_OK,
                                                            n_ts, c - 13'(n_ts)});
                                n_mode = tlx_pkg::M_IDLE;
                            end
                        end
                        tlx_pkg::M_OP: begin
                            k = tlx_pkg::pair_kind(n_h0, b);
                            if (n_h0 == 8'h2f && b == 8'h2f) begin
                                n_mode = tlx_pkg::M_COMMENT;
                                done   = 1'b1;
                            end else if (k[6]) begin
                                bd = tlx_pkg::add_res(bd, '{k[5:0], tlx_pkg::ST_OK, n_ts,
                                                            13'd0});
                                n_mode = tlx_pkg::M_IDLE;
                                done   = 1'b1;
                            end else begin
                                k = tlx_pkg::single_kind(n_h0);
                                bd = tlx_pkg::add_res(bd, '{k[5:0], tlx_pkg::ST_OK, n_ts,
                                                            13'd0});
                                n_mode = tlx_pkg::M_IDLE;
                            end
                        end
                        tlx_pkg::M_STR: begin
                            if (b == 8'h22) begin
                                bd = tlx_pkg::add_res(bd, '{tlx_pkg::K_STRING, tlx_pkg::ST_OK,
                                                            n_ts, c - 13'(n_ts) - 13'd1});
                                n_mode = tlx_pkg::M_IDLE;
                            end else if (b == 8'h5c) begin
                                n_mode = tlx_pkg::M_ESC;
                            end
                            done = 1'b1;
                        end
                        tlx_pkg::M_ESC: begin
                            if (b == 8'h0a) begin
                                bd = tlx_pkg::add_res(bd, '{6'd0, tlx_pkg::ST_UNK, n_ts,
                                                            13'd0});
                                n_err  = 1'b1;
                                n_mode = tlx_pkg::M_IDLE;
                            end else begin
                                n_mode = tlx_pkg::M_STR;
                            end
                            done = 1'b1;
                        end
                        tlx_pkg::M_COMMENT: done = 1'b1;
                        default: begin
                            done = 1'b1;
                            k = tlx_pkg::imm_kind(b);
                            if (!tlx_pkg::is_space(b)) begin
                                n_ts = c[11:0];
                                if (tlx_pkg::is_alpha(b)) begin
                                    n_pf   = {56'd0, b};
                                    n_mode = tlx_pkg::M_IDENT;
                                end else if (b == 8'h30) begin
                                    n_mode = tlx_pkg::M_ZERO;
                                end else if (tlx_pkg::is_digit(b)) begin
                                    n_mode = tlx_pkg::M_DEC;
                                end else if (b == 8'h22) begin
                                    n_mode = tlx_pkg::M_STR;
                                end else if (tlx_pkg::single_kind(b) != 7'd0) begin
                                    n_h0   = b;
                                    n_mode = tlx_pkg::M_OP;
                                end else if (k[6]) begin
                                    bd = tlx_pkg::add_res(bd, '{k[5:0], tlx_pkg::ST_OK,
                                                                c[11:0], 13'd0});
                                end else begin
                                    bd = tlx_pkg::add_res(bd, '{6'd0, tlx_pkg::ST_UNK,
                                                                c[11:0], 13'd0});
                                    n_err = 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
        end
    end

    assign o_ready  = !i_q_full;
    assign o_push   = i_valid && o_ready && !r_err && bd.cnt != 2'd0;
    assign o_bundle = bd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= tlx_pkg::M_IDLE;
            r_ts   <= '0;
            r_col  <= '0;
            r_h0   <= '0;
            r_h1   <= '0;
            r_pf   <= '0;
            r_line <= 16'd1;
            r_err  <= 1'b0;
        end else if (i_valid && o_ready && !r_err) begin
            r_mode <= n_mode;
            r_ts   <= n_ts;
            r_col  <= n_col;
            r_h0   <= n_h0;
            r_h1   <= n_h1;
            r_pf   <= n_pf;
            r_line <= n_line;
            r_err  <= n_err;
        end
    end
endmodule

// ===== design/tlx_queue.sv =====
// ----------------------------------------------------------------------------
// tlx_queue
// Short FIFO of result bundles between the scanner and the output side.
// ----------------------------------------------------------------------------
module tlx_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tlx_pkg::t_bundle i_bundle,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output tlx_pkg::t_bundle o_head
);
    tlx_pkg::t_bundle r_mem [tlx_pkg::QDepth];
    logic [tlx_pkg::QPtrW-1:0] r_wp, r_rp;
    logic [tlx_pkg::QPtrW:0]   r_cnt;

    assign o_full  = r_cnt == (tlx_pkg::QPtrW + 1)'(tlx_pkg::QDepth);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_bundle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (tlx_pkg::QPtrW + 1)'(i_push) - (tlx_pkg::QPtrW + 1)'(i_pop);
        end
    end
endmodule

// ===== design/tlx_back.sv =====
// ----------------------------------------------------------------------------
// tlx_back
// Serializes each queued bundle into single token items and marks the last.
// ----------------------------------------------------------------------------
module tlx_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  tlx_pkg::t_bundle i_head,
    output logic             o_pop,
    tlx_out_if.source        o_out
);
    logic [1:0]    r_sub;
    logic          last;
    tlx_pkg::t_res cur;

    assign cur  = i_head.r[r_sub];
    assign last = r_sub == i_head.cnt - 2'd1;

    assign o_out.valid        = !i_empty;
    assign o_out.token_kind   = cur.kind;
    assign o_out.status       = cur.status;
    assign o_out.line_number  = i_head.line;
    assign o_out.start_column = cur.col;
    assign o_out.value_length = cur.len;
    assign o_out.last_result  = last;
    assign o_pop = o_out.valid && o_out.ready && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= '0;
        end else if (o_out.valid && o_out.ready) begin
            // advance within the bundle, back to the first slot on the last one
            r_sub <= last ? 2'd0 : r_sub + 2'd1;
        end
    end
endmodule

// ===== design/token_lexer_byte_stream_top.sv =====
// ----------------------------------------------------------------------------
// token_lexer_byte_stream_top
// Streaming lexer: source bytes in, tokens of a small C-like language out.
// ----------------------------------------------------------------------------
// One source byte (or an end-of-line marker) is taken per cycle whenever the
// four-entry result queue has room. The scanner classifies the byte in that
// same cycle and turns it into zero to three token items, which the output side
// hands out one per cycle while the sink is ready; an item that yields no token
// adds nothing at the output. Sustained input rate is one item per cycle as long
// as the output drains at least one token per input item; bursts of several
// tokens per byte are soaked up by the queue. After the first error result
// (unknown byte, unterminated string, over-long line) input is still taken but
// dropped until reset.
module token_lexer_byte_stream_top #(
    parameter int MAX_LINE_BYTES = tlx_pkg::MaxLineBytesDef
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tlx_in_if.sink    i_in,
    tlx_out_if.source o_out
);
    logic             push, pop, full, empty;
    tlx_pkg::t_bundle bundle, head;

    // front: scan and classify bytes
    tlx_front #(.MAX_LINE_BYTES(MAX_LINE_BYTES)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in.valid),
        .i_char_byte   (i_in.char_byte),
        .i_end_of_line (i_in.end_of_line),
        .i_q_full      (full),
        .o_ready       (i_in.ready),
        .o_push        (push),
        .o_bundle      (bundle)
    );

    // hold bundles so each side can stall on its own
    tlx_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (bundle),
        .i_pop    (pop),
        .o_full   (full),
        .o_empty  (empty),
        .o_head   (head)
    );

    // back: hand out tokens one item at a time
    tlx_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );
endmodule

// ===== dv/tb_token_lexer_byte_stream_top.sv =====
// ----------------------------------------------------------------------------
// tb_token_lexer_byte_stream_top
// Self-checking bench for the streaming lexer: a byte-level token predictor
// builds expected tokens per accepted item, a monitor compares each output item.
// ----------------------------------------------------------------------------
module tb_token_lexer_byte_stream_top;
    import tlx_pkg::*;

    localparam int MaxLine = 4096;

    typedef struct {
        logic [5:0]  kind;
        logic [1:0]  status;
        logic [15:0] line;
        logic [11:0] col;
        logic [12:0] len;
        logic        last;
    } t_tok;

    typedef struct {
        logic [7:0] ch;
        logic       eol;
    } t_src;

    logic i_clk;
    logic i_rst_n;
    tlx_in_if  in_ch();
    tlx_out_if out_ch();

    token_lexer_byte_stream_top uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    // Predictor state
    t_mode       lx_mode;
    int unsigned lx_tstart;
    int unsigned lx_col;
    logic [7:0]  lx_op;
    logic [7:0]  lx_pfx;
    logic [63:0] lx_word;
    logic [15:0] lx_line;
    bit          lx_dead;
    t_tok        step_toks[$];

    t_src pending_src[$];
    t_tok expected_toks[$];
    int   err_cnt;
    bit   src_done;
    bit   hold_sink;
    bit   calm;

    initial begin
        i_clk = 1'b0;
    end
    always #4 i_clk = ~i_clk;

    // Keyword tables, first eight bytes packed as in a shift register
    function automatic logic [63:0] kw_pack(string s);
        logic [63:0] p;
        p = 0;
        for (int j = 0; j < s.len() && j < 8; j++) p = (p << 8) | s[j];
        return p;
    endfunction

    function automatic bit c_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction
    function automatic bit c_alpha(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction
    function automatic bit c_hex(logic [7:0] b);
        return c_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction
    function automatic bit c_space(logic [7:0] b);
        return b == 8'h09 || b == 8'h0a || b == 8'h0c || b == 8'h0d || b == 8'h20;
    endfunction

    function automatic int op_one(logic [7:0] b);
        case (b)
            "<": return 37; ">": return 36; "&": return 29; "|": return 30;
            "+": return 23; "-": return 24; "*": return 25; "/": return 26;
            "%": return 27; "=": return 39; "!": return 38;
            default: return -1;
        endcase
    endfunction

    function automatic int op_two(logic [7:0] a, logic [7:0] b);
        if (a == "<" && b == "<") return 13;
        if (a == ">" && b == ">") return 14;
        if (a == "<" && b == "-") return 15;
        if (a == "&" && b == "&") return 16;
        if (a == "|" && b == "|") return 17;
        if (b == "=") begin
            case (a)
                "+": return 18; "-": return 19; "*": return 20; "/": return 21;
                "%": return 22; ">": return 32; "<": return 33; "=": return 34;
                "!": return 35;
                default: return -1;
            endcase
        end
        return -1;
    endfunction

    function automatic int punct_kind(logic [7:0] b);
        case (b)
            "~": return 28; "^": return 31; "{": return 40; "}": return 41;
            "(": return 42; ")": return 43; "[": return 44; "]": return 45;
            ",": return 46; ";": return 47;
            default: return -1;
        endcase
    endfunction

    task automatic push_tok(int kind, int status, int unsigned col, int unsigned len);
        t_tok t;
        if (step_toks.size() >= 4) return;
        t.kind = 6'(kind); t.status = 2'(status); t.line = lx_line;
        t.col = 12'(col); t.len = 13'(len); t.last = 1'b0;
        step_toks = {step_toks, t};
    endtask

    task automatic flag_error(int status, int unsigned col);
        push_tok(0, status, col, 0);
        lx_dead = 1'b1;
        lx_mode = M_IDLE;
    endtask

    task automatic close_word(int unsigned stop);
        string kws[13];
        int unsigned n;
        n = stop - lx_tstart;
        kws = '{"int", "fixed", "ptr", "void", "function", "inline", "if", "else",
                "return", "while", "for", "continue", "break"};
        if (n <= 8) begin
            for (int i = 0; i < 13; i++) begin
                if (kws[i].len() == n && kw_pack(kws[i]) == lx_word) begin
                    push_tok(i, ST_OK, lx_tstart, 0);
                    return;
                end
            end
        end
        push_tok(K_IDENT, ST_OK, lx_tstart, n);
    endtask

    // "0x"/"0b" with no digit: the zero, then a word from the letter
    task automatic split_prefix();
        push_tok(K_NUMBER, ST_OK, lx_tstart, 1);
        lx_tstart++;
        lx_word = {56'd0, lx_pfx};
        lx_mode = M_IDENT;
    endtask

    task automatic begin_token(logic [7:0] b, int unsigned col);
        if (c_space(b)) return;
        lx_tstart = col;
        if (c_alpha(b)) begin
            lx_word = {56'd0, b};
            lx_mode = M_IDENT;
        end else if (b == "0") lx_mode = M_ZERO;
        else if (c_digit(b)) lx_mode = M_DEC;
        else if (b == "\"") lx_mode = M_STR;
        else if (op_one(b) >= 0) begin
            lx_op = b;
            lx_mode = M_OP;
        end else if (punct_kind(b) >= 0) push_tok(punct_kind(b), ST_OK, col, 0);
        else flag_error(ST_UNK, col);
    endtask

    task automatic scan_byte(logic [7:0] b, int unsigned col);
        int k;
        forever begin
            case (lx_mode)
                M_IDENT: begin
                    if (c_alpha(b) || c_digit(b) || b == "_") begin
                        if (col - lx_tstart < 8) lx_word = (lx_word << 8) | b;
                        return;
                    end
                    close_word(col);
                end
                M_ZERO: begin
                    if (b == "x" || b == "b") begin
                        lx_pfx = b;
                        lx_mode = (b == "x") ? M_HEX0 : M_BIN0;
                        return;
                    end
                    if (c_digit(b)) begin lx_mode = M_DEC; return; end
                    if (b == ".") begin lx_mode = M_FIX; return; end
                    push_tok(K_NUMBER, ST_OK, lx_tstart, col - lx_tstart);
                end
                M_DEC: begin
                    if (c_digit(b)) return;
                    if (b == ".") begin lx_mode = M_FIX; return; end
                    push_tok(K_NUMBER, ST_OK, lx_tstart, col - lx_tstart);
                end
                M_FIX: begin
                    if (c_digit(b)) return;
                    push_tok(K_FIXNUM, ST_OK, lx_tstart, col - lx_tstart);
                end
                M_HEX0: begin
                    if (c_hex(b)) begin lx_mode = M_HEX; return; end
                    split_prefix();
                    continue;
                end
                M_BIN0: begin
                    if (b == "0" || b == "1") begin lx_mode = M_BIN; return; end
                    split_prefix();
                    continue;
                end
                M_HEX: begin
                    if (c_hex(b)) return;
                    push_tok(K_NUMBER, ST_OK, lx_tstart, col - lx_tstart);
                end
                M_BIN: begin
                    if (b == "0" || b == "1") return;
                    push_tok(K_NUMBER, ST_OK, lx_tstart, col - lx_tstart);
                end
                M_OP: begin
                    if (lx_op == "/" && b == "/") begin lx_mode = M_COMMENT; return; end
                    k = op_two(lx_op, b);
                    if (k >= 0) begin
                        push_tok(k, ST_OK, lx_tstart, 0);
                        lx_mode = M_IDLE;
                        return;
                    end
                    push_tok(op_one(lx_op), ST_OK, lx_tstart, 0);
                end
                M_STR: begin
                    if (b == "\"") begin
                        push_tok(K_STRING, ST_OK, lx_tstart, col - lx_tstart - 1);
                        lx_mode = M_IDLE;
                    end else if (b == "\\") lx_mode = M_ESC;
                    return;
                end
                M_ESC: begin
                    if (b == 8'h0a) flag_error(ST_UNK, lx_tstart);
                    else lx_mode = M_STR;
                    return;
                end
                M_COMMENT: return;
                default: begin
                    begin_token(b, col);
                    return;
                end
            endcase
            lx_mode = M_IDLE;
        end
    endtask

    task automatic close_line();
        case (lx_mode)
            M_IDENT: close_word(lx_col);
            M_ZERO, M_DEC, M_HEX, M_BIN:
                push_tok(K_NUMBER, ST_OK, lx_tstart, lx_col - lx_tstart);
            M_FIX: push_tok(K_FIXNUM, ST_OK, lx_tstart, lx_col - lx_tstart);
            M_HEX0, M_BIN0: begin
                split_prefix();
                close_word(lx_col);
            end
            M_OP: push_tok(op_one(lx_op), ST_OK, lx_tstart, 0);
            M_STR, M_ESC: flag_error(ST_UNTRM, lx_tstart);
            default: ;
        endcase
        lx_mode = M_IDLE;
        lx_col = 0;
        if (lx_line != 16'hffff) lx_line++;
    endtask

    // Advance the predictor by one accepted item and queue its tokens
    task automatic predict_tokens(t_src s);
        if (lx_dead) return;
        step_toks.delete();
        if (s.eol) close_line();
        else if (lx_col >= MaxLine) flag_error(ST_LONG, 0);
        else begin
            scan_byte(s.ch, lx_col);
            lx_col++;
        end
        if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
        foreach (step_toks[i]) expected_toks = {expected_toks, step_toks[i]};
    endtask

    // Stimulus helpers
    task automatic add_text(string s);
        t_src e;
        for (int i = 0; i < s.len(); i++) begin
            e.ch = s[i]; e.eol = 1'b0;
            pending_src = {pending_src, e};
        end
    endtask

    task automatic add_eol();
        t_src e;
        e.ch = 8'($urandom);
        e.eol = 1'b1;
        pending_src = {pending_src, e};
    endtask

    // Lexemes with a dot lead with a space so a word or number never runs into the dot
    function automatic string rand_lexeme();
        string pieces[];
        string s;
        pieces = '{"int", "fixed", "ptr", "void", "function", "inline", "if", "else",
                   "return", "while", "for", "continue", "break", "<<", ">>", "<-",
                   "&&", "||", "+=", "-=", "*=", "/=", "%=", "+", "-", "*", "/", "%",
                   "~", "&", "|", "^", ">=", "<=", "==", "!=", ">", "<", "!", "=",
                   "{", "}", "(", ")", "[", "]", ",", ";", " 3.14", "0x1F", "0b101",
                   "42", "0", "0x", "0bz", "foo_9", "Zq", "breaks", "\"a\\\"b\"",
                   " ", "\t", " 0.", " 7.", "whilex", "x"};
        s = pieces[$urandom_range(pieces.size()-1)];
        if ($urandom_range(3) == 0) s = {s, " "};
        return s;
    endfunction

    // Source fill: directed cases, then random lines; errors only at the end
    initial begin
        string line;
        add_text("int fixed ptr void function inline if else return while for");
        add_eol();
        add_text("continue break<<>><-&&||+=-=*=/=%=+-*%~&|^>=<=!=>< ! = == a/");
        add_eol();
        add_text("{}()[],; 0x 0b 0break 0xAf 0b10 0.5 12.3 007 \"s\\\"q\" x//c @");
        add_eol();
        add_text("0b");
        add_eol();
        add_text("0x");
        add_eol();
        add_text("\"\"");
        add_text("/");
        add_eol();
        add_eol();
        while (pending_src.size() < 330) begin
            line = "";
            repeat ($urandom_range(8, 1)) line = {line, rand_lexeme()};
            add_text(line);
            if ($urandom_range(4) == 0) add_text("//x\xff\x80\x01");
            add_eol();
        end
        // Cover every byte bit inside a comment, then end on a random error
        add_text("//\xff\x00");
        add_eol();
        case ($urandom_range(2))
            0: add_text("a @");
            1: begin add_text("\"ab"); add_eol(); end
            default: add_text("\"\\\n");
        endcase
        add_text("x;");
        add_eol();
        src_done = 1'b1;
    end

    // Driver: offer the oldest pending item, idle about 31% outside the calm stretch
    int sent_cnt;
    bit paused;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.char_byte <= 8'd0;
            in_ch.end_of_line <= 1'b0;
            sent_cnt <= 0;
            paused <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_tokens('{ch: in_ch.char_byte, eol: in_ch.end_of_line});
                void'(pending_src.pop_front());
                sent_cnt <= sent_cnt + 1;
                // hold off once until the output has fully drained
                if (sent_cnt == 150) paused <= 1'b1;
            end
            if (paused && expected_toks.size() == 0 && !(in_ch.valid && in_ch.ready))
                paused <= 1'b0;
            if (pending_src.size() > 0 && !paused
                && (calm || $urandom_range(99) >= 31)) begin
                in_ch.valid <= 1'b1;
                in_ch.char_byte <= pending_src[0].ch;
                in_ch.end_of_line <= pending_src[0].eol;
            end else if (!in_ch.valid || in_ch.ready) begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Stall control: a long hold-off of the sink early on, then random stalls but for a calm stretch
    int cyc;
    always @(posedge i_clk) begin
        if (!i_rst_n) cyc <= 0;
        else cyc <= cyc + 1;
        calm <= (cyc >= 250 && cyc < 400);
        hold_sink <= (cyc >= 40 && cyc < 120);
    end

    // Monitor: compare each token with the oldest expectation
    always @(posedge i_clk) begin
        t_tok e;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_toks.size() == 0) begin
                    $display("%0t: unexpected token kind=%0d status=%0d", $time,
                             out_ch.token_kind, out_ch.status);
                    err_cnt++;
                end else begin
                    e = expected_toks.pop_front();
                    if (e.kind !== out_ch.token_kind || e.status !== out_ch.status
                        || e.line !== out_ch.line_number || e.col !== out_ch.start_column
                        || e.len !== out_ch.value_length || e.last !== out_ch.last_result) begin
                        $display("%0t: expected k=%0d s=%0d ln=%0d c=%0d len=%0d last=%0d",
                                 $time, e.kind, e.status, e.line, e.col, e.len, e.last);
                        $display("%0t: actual   k=%0d s=%0d ln=%0d c=%0d len=%0d last=%0d",
                                 $time, out_ch.token_kind, out_ch.status,
                                 out_ch.line_number, out_ch.start_column,
                                 out_ch.value_length, out_ch.last_result);
                        err_cnt++;
                    end
                end
            end
            out_ch.ready <= !hold_sink && (calm || $urandom_range(99) >= 31);
        end
    end

    // Reset, then wait for the stimulus to drain
    initial begin
        lx_mode = M_IDLE; lx_tstart = 0; lx_col = 0; lx_op = 0; lx_pfx = 0;
        lx_word = 0; lx_line = 16'd1; lx_dead = 1'b0;
        err_cnt = 0; calm = 1'b0; hold_sink = 1'b0;
        in_ch.valid = 1'b0; in_ch.char_byte = 8'd0; in_ch.end_of_line = 1'b0;
        out_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (src_done && pending_src.size() == 0 && expected_toks.size() == 0);
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0 && expected_toks.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Limit the run
    initial begin
        #400000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/tlx_pkg.sv
design/tlx_if.sv
design/tlx_front.sv
design/tlx_queue.sv
design/tlx_back.sv
design/token_lexer_byte_stream_top.sv
dv/tb_token_lexer_byte_stream_top.sv
